// ===== src/ppp_pkg.sv =====
// Shared types, codes and constants for the perspective point projector.
package ppp_pkg;

    // Default number of fraction bits in every fixed-point word.
    localparam int FRAC_BITS_DEF = 16;

    // Quotient width of the ratio x/w; w is at least 0.1, so |x/w| < 2^35.
    localparam int QUO_W = 35;

    // Reset values of the viewport size registers.
    localparam logic [13:0] WIDTH_RST  = 14'd1024;
    localparam logic [13:0] HEIGHT_RST = 14'd768;

    // Command codes.
    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_PROJECT = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // One classified command word as it travels through the queue.
    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } t_item;

endpackage

// ===== src/perspective_point_projector.sv =====
// Top level of the perspective point projector.
//
//  channel   handshake                    payload
//  command   i_start / o_busy             i_command, i_coef_index, i_coef_value,
//                                          i_point_x, i_point_y, i_point_z
//  result    o_result_valid (strobe)      o_visible, o_screen_x, o_screen_y
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command word is taken per cycle while o_busy is low. A projection passes
// the holding register, queue, transform, 35-stage divider and viewport stages.
// A load writes one coefficient and gives no result.
// Reset clears the coefficient store and sets the viewport to 1024 by 768.
// The result side cannot stall; o_busy rises only if the queue fills.
module perspective_point_projector import ppp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [3:0]  i_coef_index,
    input  logic [31:0] i_coef_value,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    output logic        o_result_valid,
    output logic        o_visible,
    output logic [31:0] o_screen_x,
    output logic [31:0] o_screen_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    logic        bk_valid;
    logic [13:0] r_wd, r_ht;
    logic        q_full, q_valid, push, pop;
    t_item       f_item, q_item;

    assign o_cfg_ready = 1'b1;

    // Viewport size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd <= WIDTH_RST;
            r_ht <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_wd <= i_cfg_data;
                CFG_HEIGHT: r_ht <= i_cfg_data;
                default:    r_wd <= r_wd;
            endcase
        end
    end

    ppp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_command    (i_command),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_busy       (o_busy),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (f_item)
    );

    ppp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    // The back end takes a word in the cycle it sits at the queue head.
    assign bk_valid = q_valid && pop;

    ppp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (bk_valid),
        .i_item         (q_item),
        .o_ready        (pop),
        .i_width        (r_wd),
        .i_height       (r_ht),
        .o_result_valid (o_result_valid),
        .o_visible      (o_visible),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y)
    );

endmodule

// ===== src/ppp_front.sv =====
// Front end: takes command words and holds one classified word for the queue.
module ppp_front import ppp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_command,
    input  logic [3:0]  i_coef_index,
    input  logic [31:0] i_coef_value,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    output logic        o_busy,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    // The held word leaves whenever the queue has room.
    assign o_push = r_valid && !i_q_full;
    assign o_busy = r_valid && i_q_full;
    assign take   = i_start && !o_busy;
    assign o_item = r_item;

    // Valid flag of the holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Classify the word: a load keeps only the coefficient, a projection only the point.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.cmd <= t_cmd'(i_command);
            if (t_cmd'(i_command) == CMD_LOAD) begin
                r_item.idx <= i_coef_index;
                r_item.val <= i_coef_value;
                r_item.px  <= '0;
                r_item.py  <= '0;
                r_item.pz  <= '0;
            end else begin
                r_item.idx <= '0;
                r_item.val <= '0;
                r_item.px  <= i_point_x;
                r_item.py  <= i_point_y;
                r_item.pz  <= i_point_z;
            end
        end
    end

endmodule

// ===== src/ppp_queue.sv =====
// Two-entry queue between the front end and the projection pipeline.
module ppp_queue import ppp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item       r_mem [0:1];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !do_pop |-> !i_push) else $error("push into full queue");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== src/ppp_back.sv =====
// Back end: coefficient store and the pipelined transform, divide and viewport stages.
module ppp_back import ppp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_ready,
    input  logic [13:0] i_width,
    input  logic [13:0] i_height,
    output logic        o_result_valid,
    output logic        o_visible,
    output logic [31:0] o_screen_x,
    output logic [31:0] o_screen_y
);

    localparam int CW = 31 + QUO_W;
    localparam logic signed [31:0] W_MIN = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // The pipeline never stalls, so every word is popped at once.
    assign o_ready = 1'b1;

    // Coefficient store, column-major.
    logic [31:0] r_m [0:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_m[i] <= '0;
            end
        end else if (i_valid && i_item.cmd == CMD_LOAD) begin
            r_m[i_item.idx] <= i_item.val;
        end
    end

    // Stage 1: the nine products of the used rows.
    logic               r1_v;
    logic signed [63:0] r1_p [0:8];
    logic signed [31:0] r1_t [0:2];
    logic signed [31:0] px, py, pz;

    assign px = $signed(i_item.px);
    assign py = $signed(i_item.py);
    assign pz = $signed(i_item.pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid && i_item.cmd == CMD_PROJECT;
        end
    end

    // Rows 0, 1 and 3 give x, y and w.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r1_p[3*r]     <= px * $signed(r_m[(r == 2) ? 3 : r]);
            r1_p[3*r + 1] <= py * $signed(r_m[(r == 2) ? 7 : 4 + r]);
            r1_p[3*r + 2] <= pz * $signed(r_m[(r == 2) ? 11 : 8 + r]);
            r1_t[r]       <= $signed(r_m[(r == 2) ? 15 : 12 + r]);
        end
    end

    // Stage 2: scaled sums, saturated to 32 bits.
    logic               r2_v;
    logic signed [31:0] r2_c [0:2];
    logic signed [65:0] e0 [0:2];
    logic signed [65:0] e1 [0:2];
    logic signed [65:0] e2 [0:2];
    logic signed [65:0] et [0:2];
    logic signed [65:0] sm [0:2];
    logic signed [31:0] sat_c [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            e0[r] = r1_p[3*r];
            e1[r] = r1_p[3*r + 1];
            e2[r] = r1_p[3*r + 2];
            et[r] = r1_t[r];
            sm[r] = (e0[r] >>> FRAC_BITS) + (e1[r] >>> FRAC_BITS)
                  + (e2[r] >>> FRAC_BITS) + et[r];
            if (sm[r] > 66'sd2147483647) begin
                sat_c[r] = 32'sh7FFFFFFF;
            end else if (sm[r] < -66'sd2147483648) begin
                sat_c[r] = 32'sh80000000;
            end else begin
                sat_c[r] = sm[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r2_c[r] <= sat_c[r];
        end
    end

    // Divider pipeline: one quotient bit of x/w and y/w per stage.
    logic              r_dv   [0:QUO_W];
    logic              r_vis  [0:QUO_W];
    logic              r_sx   [0:QUO_W];
    logic              r_sy   [0:QUO_W];
    logic [30:0]       r_div  [0:QUO_W];
    logic [CW-1:0]     r_rx   [0:QUO_W];
    logic [CW-1:0]     r_ry   [0:QUO_W];
    logic [QUO_W-1:0]  r_qx   [0:QUO_W];
    logic [QUO_W-1:0]  r_qy   [0:QUO_W];
    logic              vis_c;
    logic [31:0]       mag_x, mag_y;

    // Stage 3: visibility test and operand magnitudes.
    assign vis_c = (r2_c[2] >= W_MIN);
    assign mag_x = r2_c[0][31] ? (~r2_c[0] + 32'd1) : r2_c[0];
    assign mag_y = r2_c[1][31] ? (~r2_c[1] + 32'd1) : r2_c[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vis[0] <= vis_c;
        r_sx[0]  <= r2_c[0][31];
        r_sy[0]  <= r2_c[1][31];
        r_qx[0]  <= '0;
        r_qy[0]  <= '0;
        if (vis_c) begin
            r_div[0] <= r2_c[2][30:0];
            r_rx[0]  <= CW'(mag_x) << FRAC_BITS;
            r_ry[0]  <= CW'(mag_y) << FRAC_BITS;
        end else begin
            r_div[0] <= 31'd1;
            r_rx[0]  <= '0;
            r_ry[0]  <= '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int B = QUO_W - 1 - k;
        logic [CW-1:0] trial;
        logic          ge_x, ge_y;

        assign trial = CW'(r_div[k]) << B;
        assign ge_x  = (r_rx[k] >= trial);
        assign ge_y  = (r_ry[k] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        // Restoring step: subtract the shifted divisor where it fits.
        always_ff @(posedge i_clk) begin
            r_vis[k+1] <= r_vis[k];
            r_sx[k+1]  <= r_sx[k];
            r_sy[k+1]  <= r_sy[k];
            r_div[k+1] <= r_div[k];
            r_rx[k+1]  <= ge_x ? (r_rx[k] - trial) : r_rx[k];
            r_ry[k+1]  <= ge_y ? (r_ry[k] - trial) : r_ry[k];
            r_qx[k+1]  <= r_qx[k] | (QUO_W'(ge_x) << B);
            r_qy[k+1]  <= r_qy[k] | (QUO_W'(ge_y) << B);
        end
    end

    // Signed ratios, truncated toward zero.
    logic                   rn_v, rn_vis;
    logic signed [QUO_W:0]  rn_x, rn_y;
    logic signed [QUO_W:0]  qx_s, qy_s;

    assign qx_s = $signed({1'b0, r_qx[QUO_W]});
    assign qy_s = $signed({1'b0, r_qy[QUO_W]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_v <= 1'b0;
        end else begin
            rn_v <= r_dv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        rn_vis <= r_vis[QUO_W];
        rn_x   <= r_sx[QUO_W] ? -qx_s : qx_s;
        rn_y   <= r_sy[QUO_W] ? -qy_s : qy_s;
    end

    // Viewport scale products.
    localparam int PW = QUO_W + 16;
    logic                 rp_v, rp_vis;
    logic signed [PW-1:0] rp_x, rp_y;
    logic signed [14:0]   wd_s, ht_s;

    assign wd_s = $signed({1'b0, i_width});
    assign ht_s = $signed({1'b0, i_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_v <= 1'b0;
        end else begin
            rp_v <= rn_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rp_vis <= rn_vis;
        rp_x   <= PW'(wd_s * rn_x);
        rp_y   <= PW'(ht_s * rn_y);
    end

    // Half-size offset, y flip and saturation.
    logic signed [PW+1:0] hx, hy, ox, oy, fx, fy;
    logic signed [31:0]   sat_x, sat_y;

    always_comb begin
        hx = rp_x;
        hy = rp_y;
        ox = $signed((PW+2)'(i_width)) <<< (FRAC_BITS - 1);
        oy = $signed((PW+2)'(i_height)) <<< (FRAC_BITS - 1);
        fx = (hx >>> 1) + ox;
        fy = oy - (hy >>> 1);
        if (fx > (PW+2)'(64'sd2147483647)) begin
            sat_x = 32'sh7FFFFFFF;
        end else if (fx < -(PW+2)'(64'sd2147483648)) begin
            sat_x = 32'sh80000000;
        end else begin
            sat_x = fx[31:0];
        end
        if (fy > (PW+2)'(64'sd2147483647)) begin
            sat_y = 32'sh7FFFFFFF;
        end else if (fy < -(PW+2)'(64'sd2147483648)) begin
            sat_y = 32'sh80000000;
        end else begin
            sat_y = fy[31:0];
        end
    end

    // Output register; the strobe lasts one cycle per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= rp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_visible  <= rp_vis;
        o_screen_x <= rp_vis ? sat_x : 32'd0;
        o_screen_y <= rp_vis ? sat_y : 32'd0;
    end

`ifndef SYNTHESIS
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_visible |-> o_screen_x == 32'd0 && o_screen_y == 32'd0)
        else $error("hidden point gave nonzero coordinates");
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QUO_W] |-> r_rx[QUO_W] < CW'(r_div[QUO_W]))
        else $error("x remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QUO_W] |-> r_ry[QUO_W] < CW'(r_div[QUO_W]))
        else $error("y remainder not below divisor");
`endif

endmodule

// ===== tb/sv/ppp_checker.sv =====
// Checker for the perspective point projector: predicts every projection and compares results.
`timescale 1ns / 1ps

module ppp_checker import ppp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_command,
    input  logic [3:0]  i_coef_index,
    input  logic [31:0] i_coef_value,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic        i_result_valid,
    input  logic        i_visible,
    input  logic [31:0] i_screen_x,
    input  logic [31:0] i_screen_y,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_projections,
    output int          o_visible_count,
    output int          o_loads
);

    localparam int     FRAC  = FRAC_BITS_DEF;
    localparam longint ONE   = longint'(1) << FRAC;
    localparam longint W_MIN = (ONE + 5) / 10;

    typedef struct {
        logic        visible;
        logic [31:0] screen_x;
        logic [31:0] screen_y;
    } t_screen_point;

    // Local copy of the coefficient store and the viewport size.
    logic signed [31:0] coef_mem [16];
    longint             view_width;
    longint             view_height;
    t_screen_point      screen_q [$];

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // One clip row: three truncated products plus the translation term.
    function automatic longint clip_value(int row, longint px, longint py, longint pz);
        longint acc;
        acc = ((px * longint'(coef_mem[row])) >>> FRAC)
            + ((py * longint'(coef_mem[4 + row])) >>> FRAC)
            + ((pz * longint'(coef_mem[8 + row])) >>> FRAC)
            + longint'(coef_mem[12 + row]);
        return sat_word(acc);
    endfunction

    function automatic t_screen_point project_point(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
        t_screen_point res;
        longint cx, cy, cw, nx, ny, sx, sy;
        cx = clip_value(0, px, py, pz);
        cy = clip_value(1, px, py, pz);
        cw = clip_value(3, px, py, pz);
        res.visible  = 1'b0;
        res.screen_x = '0;
        res.screen_y = '0;
        if (cw >= W_MIN) begin
            // Signed division in SystemVerilog truncates toward zero.
            nx = (cx * ONE) / cw;
            ny = (cy * ONE) / cw;
            sx = ((view_width * nx) >>> 1) + view_width * (ONE / 2);
            sy = -((view_height * ny) >>> 1) + view_height * (ONE / 2);
            res.visible  = 1'b1;
            res.screen_x = 32'(sat_word(sx));
            res.screen_y = 32'(sat_word(sy));
        end
        return res;
    endfunction

    // Watch all three channels at each clock edge.
    always @(posedge i_clk) begin
        t_screen_point want;
        if (!i_rst_n) begin
            foreach (coef_mem[k])
                coef_mem[k] = '0;
            view_width  = longint'(WIDTH_RST);
            view_height = longint'(HEIGHT_RST);
            screen_q.delete();
            o_fail_count    <= 0;
            o_pending       <= 0;
            o_projections   <= 0;
            o_visible_count <= 0;
            o_loads         <= 0;
        end else begin
            // Compare the result word against the oldest prediction.
            if (i_result_valid) begin
                if (screen_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result word vis=%0b x=%h y=%h",
                                 i_visible, i_screen_x, i_screen_y);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = screen_q.pop_front();
                    if (want.visible !== i_visible || want.screen_x !== i_screen_x
                            || want.screen_y !== i_screen_y) begin
                        if (o_fail_count < 10)
                            $display("ERROR: exp vis=%0b x=%h y=%h, got vis=%0b x=%h y=%h",
                                     want.visible, want.screen_x, want.screen_y,
                                     i_visible, i_screen_x, i_screen_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // Accepted command word: load updates the store, project predicts.
            if (i_start && !i_busy) begin
                if (i_command == CMD_PROJECT) begin
                    want = project_point(i_point_x, i_point_y, i_point_z);
                    screen_q.push_back(want);
                    o_projections <= o_projections + 1;
                    if (want.visible)
                        o_visible_count <= o_visible_count + 1;
                end else begin
                    coef_mem[i_coef_index] = i_coef_value;
                    o_loads <= o_loads + 1;
                end
            end
            // Viewport register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH)
                    view_width = longint'(i_cfg_data);
                else
                    view_height = longint'(i_cfg_data);
            end
            o_pending <= screen_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the perspective point projector: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ppp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_command;
    logic [3:0]  i_coef_index;
    logic [31:0] i_coef_value;
    logic [31:0] i_point_x;
    logic [31:0] i_point_y;
    logic [31:0] i_point_z;
    logic        o_result_valid;
    logic        o_visible;
    logic [31:0] o_screen_x;
    logic [31:0] o_screen_y;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [13:0] i_cfg_data;

    int fail_count, pending, projections, visible_count, loads;
    int cycle_count = 0;

    perspective_point_projector dut (.*);

    ppp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_command(i_command), .i_coef_index(i_coef_index), .i_coef_value(i_coef_value),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_result_valid(o_result_valid), .i_visible(o_visible),
        .i_screen_x(o_screen_x), .i_screen_y(o_screen_y),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_projections(projections),
        .o_visible_count(visible_count), .o_loads(loads)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Signed value within +/- range, as a 32-bit word.
    function automatic logic [31:0] rand_span(int unsigned range);
        return 32'($signed($urandom_range(2 * range, 0)) - $signed(range));
    endfunction

    // Random 32-bit word: mostly moderate values, sometimes full range or extremes.
    function automatic logic [31:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return rand_span(200 << 16);
        if (pick < 92)
            return $urandom;
        if (pick < 96)
            return 32'h7FFF_FFFF;
        return 32'h8000_0000;
    endfunction

    // Wait a random gap, then present one command word until it is taken.
    task automatic send_word(t_cmd cmd, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        gap = $urandom_range(3);
        if ($urandom_range(3) == 0)
            gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_command    <= cmd;
        i_coef_index <= idx;
        i_coef_value <= val;
        i_point_x    <= px;
        i_point_y    <= py;
        i_point_z    <= pz;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic load_coef(logic [3:0] idx, logic [31:0] val);
        send_word(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_word(CMD_PROJECT, 4'($urandom), $urandom, px, py, pz);
    endtask

    // Let all projections drain, then wait out the pipeline.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Present one register write until it is taken; the caller drops valid afterwards.
    task automatic write_cfg(t_cfg_idx idx, logic [13:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic logic [13:0] rand_size();
        case ($urandom_range(5))
            0: return 14'd0;
            1: return 14'd1;
            2: return 14'd8192;
            3: return 14'h3FFF;
            default: return 14'($urandom_range(8192, 1));
        endcase
    endfunction

    // Load a whole matrix: mostly a plausible perspective, sometimes noise.
    task automatic load_matrix();
        logic [31:0] m [16];
        bit noisy;
        noisy = ($urandom_range(3) == 0);
        foreach (m[k])
            m[k] = noisy ? rand_coord() : $urandom;
        if (!noisy) begin
            m[0]  = rand_span(4 << 16);
            m[1]  = rand_span(1 << 15);
            m[4]  = rand_span(1 << 15);
            m[5]  = rand_span(4 << 16);
            m[8]  = rand_span(1 << 15);
            m[9]  = rand_span(1 << 15);
            m[3]  = rand_span(6554);
            m[7]  = rand_span(6554);
            m[11] = 32'(65536 + $signed(rand_span(1 << 14)));
            m[15] = rand_span(2 << 16);
            m[12] = rand_span(10 << 16);
            m[13] = rand_span(10 << 16);
        end
        for (int k = 0; k < 16; k++)
            load_coef(4'(k), m[k]);
    endtask

    initial begin
        i_start      = 1'b0;
        i_command    = CMD_LOAD;
        i_coef_index = '0;
        i_coef_value = '0;
        i_point_x    = '0;
        i_point_y    = '0;
        i_point_z    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_WIDTH;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero matrix gives w of zero, so not visible.
        project(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        // Identity-like matrix with w taken from z.
        load_coef(4'd0, 32'h0001_0000);
        load_coef(4'd5, 32'h0001_0000);
        load_coef(4'd10, 32'hDEAD_BEEF);
        load_coef(4'd11, 32'h0001_0000);
        load_coef(4'd12, 32'h7FFF_FFFF);
        load_coef(4'd12, 32'h0000_0000);
        // w at and just below the visibility threshold.
        project(32'h0000_8000, 32'hFFFF_8000, 32'd6554);
        project(32'h0000_8000, 32'hFFFF_8000, 32'd6553);
        // Extremes of the point fields and saturating results.
        project(32'h8000_0000, 32'h7FFF_FFFF, 32'd6554);
        project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        project(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
        // Saturated clip sums through a large translation term.
        load_coef(4'd15, 32'h7FFF_FFFF);
        project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_coef(4'd15, 32'h8000_0000);
        project(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
        load_coef(4'd15, 32'h0000_0000);
        project(32'h0010_0000, 32'h0020_0000, 32'h0004_0000);
        wait_idle();

        // Random phases, each with its own viewport and matrix.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_cfg(CFG_WIDTH, 14'd0); write_cfg(CFG_HEIGHT, 14'h3FFF); end
                1: begin write_cfg(CFG_WIDTH, 14'd8192); write_cfg(CFG_HEIGHT, 14'd1); end
                2: begin write_cfg(CFG_WIDTH, 14'h3FFF); write_cfg(CFG_HEIGHT, 14'd0); end
                default: begin
                    write_cfg(CFG_WIDTH, rand_size());
                    write_cfg(CFG_HEIGHT, rand_size());
                end
            endcase
            i_cfg_valid <= 1'b0;
            load_matrix();
            for (int n = 0; n < 215; n++) begin
                if ($urandom_range(19) == 0)
                    load_coef(4'($urandom), rand_coord());
                else if ($urandom_range(9) < 8)
                    project(rand_span(200 << 16), rand_span(200 << 16),
                            32'($urandom_range(200 << 16, 1 << 15)));
                else
                    project(rand_coord(), rand_coord(), rand_coord());
            end
            wait_idle();
        end

        $display("Summary: %0d projections (%0d visible) and %0d coefficient loads",
                 projections, visible_count, loads);
        $display("across 8 viewport settings including zero and full-range sizes.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ppp_pkg.sv
src/ppp_front.sv
src/ppp_queue.sv
src/ppp_back.sv
src/perspective_point_projector.sv
tb/sv/ppp_checker.sv
tb/sv/tb_top.sv
